// ===== design/rle_pkg.sv =====
// shared types and constants of the run-length escape encoder
`default_nettype none

package rle_pkg;

    localparam int BYTE_W       = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CMD_DEPTH_DEF = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MARKER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN = 2'd1;

    // configuration reset values
    localparam logic [BYTE_W-1:0] MARKER_RESET  = 8'd144;
    localparam logic [BYTE_W-1:0] MAX_RUN_RESET = 8'd255;
    localparam logic [BYTE_W-1:0] MIN_RUN_LIMIT = 8'd2;

    // one run to be emitted by the back end
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] length;
        logic              last;
        logic              done;
    } cmd_t;

    // request from the front end into the queue
    typedef struct packed {
        logic push;
        cmd_t cmd;
    } cmd_req_t;

endpackage

`default_nettype wire

// ===== design/rle_front.sv =====
// front end: tracks the open run and issues run commands
`default_nettype none

module rle_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,   // data_byte
    input  wire logic                     s_tlast,   // end_of_block
    input  wire logic [7:0]               max_run,
    input  wire logic                     q_full,
    output rle_pkg::cmd_req_t             req
);
    import rle_pkg::*;

    logic [BYTE_W-1:0] run_value_reg,  run_value_next;
    logic [BYTE_W-1:0] run_length_reg, run_length_next;
    logic              pend_reg,       pend_next;
    logic [BYTE_W-1:0] limit;
    logic              extend;
    logic              s_fire;

    // run limit, short values act as two
    assign limit  = (max_run < MIN_RUN_LIMIT) ? MIN_RUN_LIMIT : max_run;
    assign extend = (run_length_reg != '0) && (s_tdata == run_value_reg)
                    && (run_length_reg < limit);
    assign s_tready = !pend_reg && !q_full;
    assign s_fire   = s_tvalid && s_tready;

    // run tracking and command issue
    always_comb
    begin
        run_value_next  = run_value_reg;
        run_length_next = run_length_reg;
        pend_next       = pend_reg;
        req             = '0;
        if (pend_reg)
        begin
            // flush of the run opened by the final byte
            if (!q_full)
            begin
                req.push        = 1'b1;
                req.cmd.value   = run_value_reg;
                req.cmd.length  = run_length_reg;
                req.cmd.last    = 1'b1;
                req.cmd.done    = 1'b1;
                run_value_next  = '0;
                run_length_next = '0;
                pend_next       = 1'b0;
            end
        end
        else if (s_fire)
        begin
            if (extend)
            begin
                if (s_tlast)
                begin
                    req.push        = 1'b1;
                    req.cmd.value   = run_value_reg;
                    req.cmd.length  = run_length_reg + 8'd1;
                    req.cmd.last    = 1'b1;
                    req.cmd.done    = 1'b1;
                    run_value_next  = '0;
                    run_length_next = '0;
                end
                else
                begin
                    run_length_next = run_length_reg + 8'd1;
                end
            end
            else if (run_length_reg != '0)
            begin
                // close the open run; on block end the new run is flushed from the pending state
                req.push        = 1'b1;
                req.cmd.value   = run_value_reg;
                req.cmd.length  = run_length_reg;
                req.cmd.last    = !s_tlast;
                req.cmd.done    = 1'b0;
                run_value_next  = s_tdata;
                run_length_next = 8'd1;
                pend_next       = s_tlast;
            end
            else if (s_tlast)
            begin
                req.push        = 1'b1;
                req.cmd.value   = s_tdata;
                req.cmd.length  = 8'd1;
                req.cmd.last    = 1'b1;
                req.cmd.done    = 1'b1;
                run_value_next  = '0;
                run_length_next = '0;
            end
            else
            begin
                run_value_next  = s_tdata;
                run_length_next = 8'd1;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg  <= '0;
            run_length_reg <= '0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            run_value_reg  <= run_value_next;
            run_length_reg <= run_length_next;
            pend_reg       <= pend_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/rle_cmd_fifo.sv =====
// short command queue between front and back end
`default_nettype none

module rle_cmd_fifo #(
    parameter int DEPTH = rle_pkg::CMD_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rle_pkg::cmd_req_t req,
    output logic                   full,
    input  wire logic              pop,
    output logic                   empty,
    output rle_pkg::cmd_t          head
);
    import rle_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t              mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = req.push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= req.cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/rle_back.sv =====
// back end: expands run commands into code bytes
`default_nettype none

module rle_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              empty,
    input  wire rle_pkg::cmd_t     head,
    output logic                   pop,
    input  wire logic [7:0]        marker,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // code_byte
    output logic                   m_tuser,   // code_last
    output logic                   m_tlast    // block_done
);
    import rle_pkg::*;

    logic [1:0]        idx_reg;
    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg, done_reg;
    logic              is_run, is_esc;
    logic [1:0]        final_idx;
    logic              is_final;
    logic [BYTE_W-1:0] cur_byte;
    logic              load;

    // byte selection for the current position in the command
    assign is_run    = (head.length >= 8'd2);
    assign is_esc    = (head.value == marker);
    assign final_idx = is_run ? 2'd2 : (is_esc ? 2'd1 : 2'd0);
    assign is_final  = (idx_reg == final_idx);

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = (is_run || is_esc) ? marker : head.value;
            2'd1:    cur_byte = is_run ? head.length : marker;
            default: cur_byte = head.value;
        endcase
    end

    assign load = !empty && (!valid_reg || m_tready);
    assign pop  = load && is_final;

    // output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= cur_byte;
            last_reg <= is_final && head.last;
            done_reg <= is_final && head.done;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= is_final ? 2'd0 : idx_reg + 2'd1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = last_reg;
    assign m_tlast  = done_reg;

endmodule

`default_nettype wire

// ===== design/rle_escape_encoder.sv =====
// Run-length encoder with escape byte: one input byte per request on s_*, coded
// bytes on m_*. The front end takes a byte in every cycle while the command queue
// has room, except that a final byte which also closes an earlier run holds the
// input until its own run has been flushed. The back end sends one coded byte
// per cycle while the sink is ready and a command is queued, so the sustained
// rate is set by the output: a closed run costs one byte (plain literal), two
// (escaped marker) or three (marker, count, value), queued as one command.
// Registers: index 0 marker byte (reset 144), index 1 max run (reset 255); write
// only while the encoder is idle.
`default_nettype none

module rle_escape_encoder #(
    parameter int CMD_DEPTH = rle_pkg::CMD_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  wire logic                           s_tlast,   // end_of_block
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] code_byte
    output logic                                m_tuser,   // [0] code_last
    output logic                                m_tlast,   // block_done
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [7:0]                     cfg_data
);
    import rle_pkg::*;

    logic [BYTE_W-1:0] marker_reg;
    logic [BYTE_W-1:0] max_run_reg;
    cmd_req_t          req;
    cmd_t              head;
    logic              q_full, q_empty, pop;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg  <= MARKER_RESET;
            max_run_reg <= MAX_RUN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MARKER)
            begin
                marker_reg <= cfg_data;
            end
            else if (cfg_index == REG_MAX_RUN)
            begin
                max_run_reg <= cfg_data;
            end
        end
    end

    // front end
    rle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .max_run  (max_run_reg),
        .q_full   (q_full),
        .req      (req)
    );

    // command queue
    rle_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .full  (q_full),
        .pop   (pop),
        .empty (q_empty),
        .head  (head)
    );

    // back end
    rle_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .head     (head),
        .pop      (pop),
        .marker   (marker_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        req.push |-> !q_full)
        else $error("command pushed into full queue");

    // back end pops only a present command
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("command popped from empty queue");

    // end of block is always also the last byte of its request
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("block end without item end");

    // input is held while a block flush is pending
    a_flush_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast && !req.cmd.done && req.push)
            |=> !s_tready)
        else $error("input taken during block flush");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// testbench for the run-length escape encoder: byte stream in, coded bytes checked on the fly
`timescale 1ns / 1ps

module tb;
    import rle_pkg::*;

    localparam int      CLK_HALF      = 6;
    localparam int      SETTLE_CYCLES = 10;
    localparam int      END_CYCLES    = 20;
    localparam longint  TIMEOUT_NS    = 20_000_000;
    localparam int      PHASE_ITEMS   = 29;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    // one coded byte as it should leave the encoder
    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              code_last;
        logic              block_done;
    } code_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;    // [7:0] data_byte
    logic                 s_tlast   = 1'b0;  // end_of_block
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;           // [7:0] code_byte
    logic                 m_tuser;           // [0] code_last
    logic                 m_tlast;           // block_done
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    // encoder state as predicted
    logic [BYTE_W-1:0] cur_marker  = MARKER_RESET;
    logic [BYTE_W-1:0] cur_max_run = MAX_RUN_RESET;
    logic [BYTE_W-1:0] open_value  = '0;
    logic [BYTE_W-1:0] open_length = '0;

    code_t             pending_codes[$];
    logic [BYTE_W-1:0] step_codes[$];
    int                mismatches  = 0;
    int                items_sent  = 0;
    int                sink_stall  = 0;
    bit                src_quiet   = 1'b0;
    bit                sink_quiet  = 1'b0;

    rle_escape_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // append one byte to the bytes of the current step
    task automatic add_code(input logic [BYTE_W-1:0] b);
        step_codes = {step_codes, b};
    endtask

    // coded bytes of one closed run
    task automatic close_run(input logic [BYTE_W-1:0] value, input logic [BYTE_W-1:0] length);
        if (length >= 2)
        begin
            add_code(cur_marker);
            add_code(length);
            add_code(value);
        end
        else if (length == 1)
        begin
            if (value == cur_marker)
            begin
                add_code(cur_marker);
                add_code(cur_marker);
            end
            else
                add_code(value);
        end
    endtask

    // predict the coded bytes caused by one accepted request
    task automatic encode_byte(input logic [BYTE_W-1:0] data, input logic eob);
        logic [BYTE_W-1:0] run_cap;
        int                n;
        code_t             c;
        run_cap = (cur_max_run < MIN_RUN_LIMIT) ? MIN_RUN_LIMIT : cur_max_run;
        step_codes.delete();
        if (open_length != 0 && data == open_value && open_length < run_cap)
            open_length = open_length + 8'd1;
        else
        begin
            close_run(open_value, open_length);
            open_value  = data;
            open_length = 8'd1;
        end
        if (eob)
        begin
            close_run(open_value, open_length);
            open_value  = '0;
            open_length = '0;
        end
        n = step_codes.size();
        for (int i = 0; i < n; i++)
        begin
            c.code_byte  = step_codes[i];
            c.code_last  = (i == n - 1);
            c.block_done = eob && (i == n - 1);
            pending_codes = {pending_codes, c};
        end
    endtask

    // one input request, with a random gap ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic eob);
        int gap;
        gap = pick_gap(src_quiet);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= eob;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        encode_byte(data, eob);
        items_sent++;
    endtask

    task automatic send_run(input logic [BYTE_W-1:0] value, input int len, input logic eob_end);
        for (int i = 0; i < len; i++)
            send_byte(value, (i == len - 1) ? eob_end : ($urandom_range(99) < 3));
    endtask

    // stop sending until every predicted byte is out and the front end has settled
    task automatic drain_codes();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MARKER:  cur_marker  = val;
            REG_MAX_RUN: cur_max_run = val;
            default: ;
        endcase
    endtask

    // literals, lone marker and a marker run with reset settings
    task automatic test_plain_and_marker();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(MARKER_RESET, 1'b0);
        send_byte(MARKER_RESET, 1'b0);
        send_byte(MARKER_RESET, 1'b1);
        send_byte(MARKER_RESET, 1'b1);
        send_byte(8'h55, 1'b1);
    endtask

    // a full run restarts, and the count byte equals the marker
    task automatic test_run_at_limit();
        drain_codes();
        write_reg(REG_MARKER, 8'd3);
        write_reg(REG_MAX_RUN, 8'd3);
        send_run(8'hAA, 3, 1'b0);
        send_byte(8'hAA, 1'b1);
    endtask

    // open run outlives a lowered max run and a new marker
    task automatic test_mid_run_change();
        drain_codes();
        write_reg(REG_MARKER, MARKER_RESET);
        write_reg(REG_MAX_RUN, MAX_RUN_RESET);
        for (int i = 0; i < 4; i++)
            send_byte(8'h7E, 1'b0);
        drain_codes();
        write_reg(REG_MAX_RUN, MIN_RUN_LIMIT);
        write_reg(REG_MARKER, 8'h7E);
        send_byte(8'h7E, 1'b1);
    endtask

    // max run of zero and one behaves as two
    task automatic test_short_max_run();
        drain_codes();
        write_reg(REG_MAX_RUN, 8'd0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h11, 1'b1);
        drain_codes();
        write_reg(REG_MAX_RUN, 8'd1);
        send_byte(8'h22, 1'b0);
        send_byte(8'h22, 1'b1);
    endtask

    // writes to unused indexes leave the settings alone
    task automatic test_unknown_index();
        drain_codes();
        write_reg(REG_UNUSED_2, 8'hFF);
        write_reg(REG_UNUSED_3, 8'h00);
        send_byte(8'h33, 1'b0);
        send_byte(8'h33, 1'b1);
    endtask

    // random runs over several settings, one stretch without idling
    task automatic test_random_runs();
        logic [BYTE_W-1:0] mk;
        logic [BYTE_W-1:0] mr;
        logic [BYTE_W-1:0] value;
        int                run_cap;
        int                len;
        int                hi;
        int                r;
        int                start;
        value = '0;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    mk = MARKER_RESET;
                    mr = MAX_RUN_RESET;
                end
                1:
                begin
                    mk = 8'h00;
                    mr = MIN_RUN_LIMIT;
                end
                2:
                begin
                    mk = 8'hFF;
                    mr = 8'd7;
                end
                3:
                begin
                    mk = 8'($urandom_range(255));
                    mr = 8'($urandom_range(255, 2));
                end
                4:
                begin
                    mk = 8'($urandom_range(255));
                    mr = 8'd1;
                end
                default:
                begin
                    mk = 8'hFF;
                    mr = MAX_RUN_RESET;
                end
            endcase
            drain_codes();
            write_reg(REG_MARKER, mk);
            write_reg(REG_MAX_RUN, mr);
            src_quiet  = (phase == 2);
            sink_quiet = (phase == 2);
            run_cap = (mr < MIN_RUN_LIMIT) ? MIN_RUN_LIMIT : mr;
            // one run past the widest count
            if (phase == 2)
                send_run(8'($urandom_range(255)), run_cap + 1, 1'b1);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                r = $urandom_range(99);
                if (r < 20)
                    value = mk;
                else if (r >= 35)
                    value = 8'($urandom_range(255));
                hi = (run_cap + 2 > 20) ? 20 : run_cap + 2;
                r = $urandom_range(99);
                if (r < 55)
                    len = 1;
                else if (r < 85)
                    len = $urandom_range(4, 2);
                else
                    len = $urandom_range(hi, 2);
                send_run(value, len, $urandom_range(99) < 20);
            end
        end
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
    endtask

    // sink side: random backpressure and comparison of each coded byte
    always @(posedge clk)
    begin : code_sink
        code_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_codes.size() == 0)
                begin
                    $error("unexpected code byte %0h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_codes.pop_front();
                    if (m_tdata !== want.code_byte)
                    begin
                        $error("code_byte: expected %0h, got %0h", want.code_byte, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== want.code_last)
                    begin
                        $error("code_last: expected %0b, got %0b", want.code_last, m_tuser);
                        mismatches++;
                    end
                    if (m_tlast !== want.block_done)
                    begin
                        $error("block_done: expected %0b, got %0b", want.block_done, m_tlast);
                        mismatches++;
                    end
                end
            end
            // ready held low for a whole gap, then a fresh pick
            if (sink_stall > 0)
            begin
                sink_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                sink_stall = pick_gap(sink_quiet);
                m_tready <= (sink_stall == 0);
                if (sink_stall > 0)
                    sink_stall--;
            end
        end
    end

    // run sequence
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_and_marker();
        test_run_at_limit();
        test_mid_run_change();
        test_short_max_run();
        test_unknown_index();
        test_random_runs();
        drain_codes();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_codes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/rle_pkg.sv
design/rle_front.sv
design/rle_cmd_fifo.sv
design/rle_back.sv
design/rle_escape_encoder.sv
sim/tb.sv
